/* rtl/core/lls_pkg.sv */
// Package: types and constants for the least-loaded selector with failure hold-off.
`timescale 1ns / 1ps
`default_nettype none
package lls_pkg;

   localparam int NUM_ENTRIES_DEF = 16;

   localparam int TASK_W = 16;
   localparam int STREAK_W = 8;
   localparam int TIME_W = 48;
   localparam int IDX_W = 4;
   localparam int EIU_W = 5;
   localparam int HOLD_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [EIU_W-1:0] EIU_RST = 5'd16;
   localparam logic [STREAK_W-1:0] LIMIT_RST = 8'd3;
   localparam logic [HOLD_W-1:0] HOLD_RST = 32'd1000000;

   localparam logic [STREAK_W-1:0] STREAK_DECAY = 8'd2;
   localparam logic [STREAK_W-1:0] STREAK_MAX = 8'hFF;
   localparam logic [TASK_W-1:0] TASK_MAX = 16'hFFFF;

   localparam logic OP_SELECT = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILURE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF_TIME = 2'd2;

   typedef struct packed {
      logic op;
      logic [TIME_W-1:0] now;
      logic [IDX_W-1:0] entry_index;
      logic succeeded;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] chosen_index;
      logic found;
   } rsp_type;

   typedef struct packed {
      logic [TASK_W-1:0] task_count;
      logic [STREAK_W-1:0] fail_streak;
      logic [TIME_W-1:0] last_fail_time;
   } entry_type;

   typedef struct packed {
      logic load;
      logic rpt_read;
      logic rpt_write;
      logic scan_start;
      logic scan_eval;
      logic sel_finish;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic scan_last;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/core/least_loaded_selector_with_backoff_unit.sv */
// Top level: least-loaded target selector with failure hold-off.
// Report item: the indexed entry is read, then updated; no result.
// Select item: scans L entries, L = min(entries_in_use, NUM_ENTRIES); one entry
// is read and evaluated per cycle through the single table read port.
// rsp_valid is high for one cycle after the final table write; the receiver cannot stall.
// Synchronous reset restores config defaults and marks all entries as zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module least_loaded_selector_with_backoff_unit import lls_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input wire logic csr_we,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   lls_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_op(req_data.op),
      .sts(sts),
      .cmd(cmd),
      .busy(busy)
   );

   lls_datapath #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/core/lls_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [AW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/lls_datapath.sv */
// Datapath: config registers, entry table, scan evaluation and result register.
`timescale 1ns / 1ps
`default_nettype none
module lls_datapath import lls_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire cmd_type cmd,
   output sts_type sts,
   input wire req_type req_data,
   input wire logic csr_we,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CW = $clog2(NUM_ENTRIES + 1);
   localparam int LW = (CW > EIU_W) ? CW : EIU_W;
   localparam int EW = $bits(entry_type);

   logic [EIU_W-1:0] eiu_ff, eiu_in;
   logic [STREAK_W-1:0] limit_ff, limit_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   req_type req_ff, req_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic have_ff, have_in;
   logic [AW-1:0] best_addr_ff, best_addr_in;
   entry_type best_ent_ff, best_ent_in;
   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic rd_valid_ff, rd_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [LW-1:0] eiu_ext, num_ext, limit_eff, scan_next_ext, idx_ext, best_ext;
   logic idx_ok;
   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr, scan_next;
   logic [EW-1:0] ram_rd, wr_data;
   entry_type cur, upd, rpt_ent, fin_ent;
   logic over_limit, held, eligible, better;
   logic [TIME_W-1:0] diff;

   assign eiu_ext = LW'(eiu_ff);
   assign num_ext = LW'(NUM_ENTRIES);
   assign limit_eff = (eiu_ext > num_ext) ? num_ext : eiu_ext;
   assign scan_next = scan_addr_ff + AW'(1);
   assign scan_next_ext = LW'(scan_addr_ff) + LW'(1);
   assign idx_ext = LW'(req_ff.entry_index);
   assign idx_ok = idx_ext < num_ext;

   assign sts.limit_zero = (limit_eff == '0);
   assign sts.scan_last = (scan_next_ext == limit_eff);

   // Current entry: never-written entries read as zero.
   assign cur = rd_valid_ff ? entry_type'(ram_rd) : entry_type'('0);

   // Hold-off test and decay for the entry under scan.
   assign diff = req_ff.now - cur.last_fail_time;
   assign over_limit = cur.fail_streak >= limit_ff;
   assign held = (req_ff.now < cur.last_fail_time) || (diff < TIME_W'(hold_ff));
   assign eligible = !(over_limit && held);
   always_comb begin
      upd = cur;
      if (over_limit) begin
         upd.fail_streak = (cur.fail_streak > STREAK_DECAY) ?
                           (cur.fail_streak - STREAK_DECAY) : '0;
         upd.last_fail_time = req_ff.now;
      end
   end
   assign better = eligible && (!have_ff || (cur.task_count < best_ent_ff.task_count));

   always_comb begin
      rpt_ent = cur;
      if (req_ff.succeeded) begin
         rpt_ent.fail_streak = '0;
      end else begin
         if (cur.fail_streak != STREAK_MAX) begin
            rpt_ent.fail_streak = cur.fail_streak + STREAK_W'(1);
         end
         rpt_ent.last_fail_time = req_ff.now;
      end
      if (cur.task_count != '0) begin
         rpt_ent.task_count = cur.task_count - TASK_W'(1);
      end
   end

   always_comb begin
      fin_ent = best_ent_ff;
      if (best_ent_ff.task_count != TASK_MAX) begin
         fin_ent.task_count = best_ent_ff.task_count + TASK_W'(1);
      end
   end

   // Table read port
   always_comb begin
      rd_en = 1'b0;
      rd_addr = scan_next;
      priority if (cmd.rpt_read) begin
         rd_en = 1'b1;
         rd_addr = idx_ext[AW-1:0];
      end else if (cmd.scan_start) begin
         rd_en = 1'b1;
         rd_addr = '0;
      end else if (cmd.scan_eval && !sts.scan_last) begin
         rd_en = 1'b1;
         rd_addr = scan_next;
      end
   end

   // Table write port
   always_comb begin
      wr_en = 1'b0;
      wr_addr = scan_addr_ff;
      wr_data = EW'(upd);
      priority if (cmd.rpt_write) begin
         wr_en = idx_ok;
         wr_addr = idx_ext[AW-1:0];
         wr_data = EW'(rpt_ent);
      end else if (cmd.scan_eval) begin
         wr_en = over_limit && !held;
         wr_addr = scan_addr_ff;
         wr_data = EW'(upd);
      end else if (cmd.sel_finish) begin
         wr_en = have_ff;
         wr_addr = best_addr_ff;
         wr_data = EW'(fin_ent);
      end
   end

   lls_ram #(
      .WIDTH(EW),
      .DEPTH(NUM_ENTRIES)
   ) u_table (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rd)
   );

   always_comb begin
      eiu_in = eiu_ff;
      limit_in = limit_ff;
      hold_in = hold_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRIES_IN_USE: eiu_in = csr_wdata[EIU_W-1:0];
            CSR_FAILURE_LIMIT: limit_in = csr_wdata[STREAK_W-1:0];
            CSR_HOLDOFF_TIME: hold_in = csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_in = cmd.load ? req_data : req_ff;
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
      end else if (cmd.scan_eval) begin
         scan_addr_in = scan_next;
      end
      have_in = have_ff;
      best_addr_in = best_addr_ff;
      best_ent_in = best_ent_ff;
      if (cmd.load) begin
         have_in = 1'b0;
      end else if (cmd.scan_eval && better) begin
         have_in = 1'b1;
         best_addr_in = scan_addr_ff;
         best_ent_in = upd;
      end
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
      best_ext = LW'(best_addr_ff);
      rsp_valid_in = cmd.sel_finish;
      rsp_data_in = rsp_data_ff;
      if (cmd.sel_finish) begin
         rsp_data_in.found = have_ff;
         rsp_data_in.chosen_index = have_ff ? best_ext[IDX_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff <= EIU_RST;
         limit_ff <= LIMIT_RST;
         hold_ff <= HOLD_RST;
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eiu_ff <= eiu_in;
         limit_ff <= limit_in;
         hold_ff <= hold_in;
         valid_ff <= valid_in;
         rd_valid_ff <= rd_valid_in;
         have_ff <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      scan_addr_ff <= scan_addr_in;
      best_addr_ff <= best_addr_in;
      best_ent_ff <= best_ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

/* rtl/core/lls_ctrl.sv */
// Controller: state machine sequencing report and select items.
`timescale 1ns / 1ps
`default_nettype none
module lls_ctrl import lls_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic req_op,
   input wire sts_type sts,
   output cmd_type cmd,
   output logic busy
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RPT_RD = 6'b000010,
      ST_RPT_WR = 6'b000100,
      ST_SEL_RD = 6'b001000,
      ST_SEL_EVAL = 6'b010000,
      ST_SEL_WR = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_op == OP_REPORT) begin
                  state_in = ST_RPT_RD;
               end else if (sts.limit_zero) begin
                  state_in = ST_SEL_WR;
               end else begin
                  state_in = ST_SEL_RD;
               end
            end
         end
         ST_RPT_RD: begin
            cmd.rpt_read = 1'b1;
            state_in = ST_RPT_WR;
         end
         ST_RPT_WR: begin
            cmd.rpt_write = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SEL_RD: begin
            cmd.scan_start = 1'b1;
            state_in = ST_SEL_EVAL;
         end
         ST_SEL_EVAL: begin
            cmd.scan_eval = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_SEL_WR;
            end
         end
         ST_SEL_WR: begin
            cmd.sel_finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire
